// ===== hw/rtl/piq_pkg.sv =====
// Shared types and constants for the positional insert queue.
package piq_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 64;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          slot;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/piq_cell.sv =====
// One storage cell of the shift chain.
module piq_cell
  import piq_pkg::*;
(
  input  logic                     clk,
  input  logic [IDX_W-1:0]         cell_idx,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value
);

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    unique case (cmd.op)
      CELL_HOLD: value_nxt = value_r;
      CELL_APPEND: begin
        if (cell_idx == cmd.slot) value_nxt = cmd.value;
      end
      CELL_INSERT: begin
        // take the new value at the slot, shift everything behind it toward the tail
        if (cell_idx == cmd.slot) begin
          value_nxt = cmd.value;
        end else if (cell_idx > cmd.slot) begin
          value_nxt = left_value;
        end
      end
      CELL_POP: value_nxt = right_value;
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== hw/rtl/piq_ctrl.sv =====
// Count register, operation decode and output register of the queue.
module piq_ctrl
  import piq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_opcode,
  input  logic signed [DATA_W-1:0] in_value_in,
  input  logic [CNT_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_fill_count,
  input  logic signed [DATA_W-1:0] head_value,
  output cell_cmd_t                cmd
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;

  logic                     accept;
  op_t                      op;
  logic                     full;
  logic                     bad_pos;
  logic [CNT_W:0]           pos_ext;
  logic [CNT_W:0]           cnt_plus1;
  logic [CNT_W-1:0]         pos_m1;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign op        = op_t'(in_opcode);
  assign full      = (count_r == FULL_CNT);
  assign pos_ext   = {1'b0, in_position};
  assign cnt_plus1 = {1'b0, count_r} + (CNT_W+1)'(1);
  assign bad_pos   = (in_position == '0) || (pos_ext > cnt_plus1);
  assign pos_m1    = in_position - CNT_W'(1);

  always_comb begin
    count_nxt      = count_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    cmd.op         = CELL_HOLD;
    cmd.slot       = count_r[IDX_W-1:0];
    cmd.value      = in_value_in;
    if (accept) begin
      out_value_nxt  = '0;
      out_status_nxt = ST_OK;
      unique case (op)
        OP_APPEND: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            cmd.op    = CELL_APPEND;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_INSERT: begin
          // position check wins over the full check
          if (bad_pos) begin
            out_status_nxt = ST_BADPOS;
          end else if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            cmd.op    = CELL_INSERT;
            cmd.slot  = pos_m1[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (count_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            cmd.op        = CELL_POP;
            out_value_nxt = head_value;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        OP_NOP: out_status_nxt = ST_OK;
        default: out_status_nxt = ST_OK;
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // fill count rides with the result: hold it while the result waits
  logic [CNT_W-1:0] out_fill_r;
  always_ff @(posedge clk) begin
    if (accept) out_fill_r <= count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_value_out  = out_value_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

endmodule

// ===== hw/rtl/positional_insert_queue.sv =====
// Top level of the positional insert queue: controller plus a chain of storage cells.
//
// A bounded ordered queue of signed 64-bit values, up to DEPTH entries.
// Input channel (in_valid / in_stall): one item carries in_opcode
// (append at tail, insert at 1-based in_position, pop head, or no-op),
// in_value_in and in_position.
// Result channel (out_valid / out_stall): one item per input item with
// out_value_out (popped head, else zero), out_status (ok, full, empty,
// bad position) and out_fill_count (entries after the operation).
// The result is registered at the edge that takes the item. Throughput is
// one item per cycle while the result channel is not stalled; every entry
// sits in its own cell and the whole row shifts toward head or tail in that
// same edge, whatever the position.
// When the receiver stalls, the result holds in the output register and
// in_stall rises until it is taken.
// Reset clears the count and the output valid; entry contents are left
// as they are and are never read before being written.
module positional_insert_queue
  import piq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_opcode,
  input  logic signed [DATA_W-1:0] in_value_in,
  input  logic [CNT_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_fill_count
);

  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_val [DEPTH];

  piq_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_value_in    (in_value_in),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_out  (out_value_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .head_value     (cell_val[0]),
    .cmd            (cmd)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = cmd.value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end

    // last cell has no right neighbor: keep its own value
    if (i == DEPTH - 1) begin : g_tail
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    piq_cell u_cell (
      .clk         (clk),
      .cell_idx    (IDX_W'(i)),
      .cmd         (cmd),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_val[i])
    );
  end

endmodule

// ===== hw/rtl/piq_chk.sv =====
// Port-level checks for the positional insert queue, bound to the top level.
module piq_chk
  import piq_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_value_out,
  input logic [1:0]               out_status,
  input logic [CNT_W-1:0]         out_fill_count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_out)
      && $stable(out_status) && $stable(out_fill_count))
    else $error("stalled result changed");

  // every accepted item shows a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_fill_count == FULL_CNT)
    else $error("full status with count below depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_fill_count == '0 && out_value_out == '0)
    else $error("empty status with stored entries or nonzero value");

endmodule

bind positional_insert_queue piq_chk u_piq_chk (.*);

// ===== tb/sv/tb_positional_insert_queue.sv =====
// Testbench for the positional insert queue: random and directed items, self-checking.
`timescale 1ns / 1ps

module tb_positional_insert_queue;
  import piq_pkg::*;

  localparam int RESET_CYCLES     = 8;
  localparam int RANDOM_ITEMS     = 900;
  localparam int CALM_ITEMS       = 120;
  localparam int LONG_HOLD_START  = 150;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_POSITION     = (1 << CNT_W) - 1;

  typedef struct {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         position;
  } queue_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic [CNT_W-1:0]         fill;
  } queue_result_t;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_opcode      = OP_NOP;
  logic signed [DATA_W-1:0] in_value_in    = '0;
  logic [CNT_W-1:0]         in_position    = '0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic signed [DATA_W-1:0] out_value_out;
  logic [1:0]               out_status;
  logic [CNT_W-1:0]         out_fill_count;

  queue_cmd_t    cmd_backlog[$];
  queue_result_t expected_results[$];

  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int shadow_count = 0;
  int gen_count    = 0;
  int items_sent   = 0;
  int errors       = 0;
  int send_gap     = 0;
  int hold_left    = 0;
  logic calm       = 1'b0;
  logic long_hold  = 1'b0;

  positional_insert_queue dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_value_in    (in_value_in),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_out  (out_value_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Queue the item and track the fill level it leaves behind, for choosing positions.
  task automatic add_cmd(input op_t op, input logic signed [DATA_W-1:0] value,
                         input int position);
    queue_cmd_t cmd;
    cmd.op       = op;
    cmd.value    = value;
    cmd.position = CNT_W'(position);
    cmd_backlog.insert(cmd_backlog.size(), cmd);
    case (op)
      OP_APPEND: if (gen_count < DEPTH) gen_count++;
      OP_INSERT: begin
        if (position >= 1 && position <= gen_count + 1 && gen_count < DEPTH) gen_count++;
      end
      OP_POP:    if (gen_count > 0) gen_count--;
      default:   ;
    endcase
  endtask

  task automatic predict_queue_result(input queue_cmd_t cmd);
    queue_result_t res;
    int n;
    int pos;
    n          = shadow_count;
    pos        = int'(cmd.position);
    res.value  = '0;
    res.status = ST_OK;
    case (cmd.op)
      OP_APPEND: begin
        if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[n] = cmd.value;
          shadow_count = n + 1;
        end
      end
      OP_INSERT: begin
        // position check wins over full
        if (pos == 0 || pos > n + 1) begin
          res.status = ST_BADPOS;
        end else if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = n; i > pos - 1; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[pos - 1] = cmd.value;
          shadow_count = n + 1;
        end
      end
      OP_POP: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = shadow_entries[0];
          for (int i = 0; i + 1 < n; i++) shadow_entries[i] = shadow_entries[i + 1];
          shadow_count = n - 1;
        end
      end
      default: ;
    endcase
    res.fill = CNT_W'(shadow_count);
    expected_results.insert(expected_results.size(), res);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (k == 1) return 64'sh8000_0000_0000_0000;
    if (k == 2) return DATA_W'($urandom_range(0, 15));
    return {$urandom, $urandom};
  endfunction

  // Mostly good positions, with the edges and some out-of-range ones mixed in.
  function automatic int rand_position();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(gen_count + 2, MAX_POSITION);
    if (k == 1) return 1;
    if (k == 2) return gen_count + 1;
    return $urandom_range(1, gen_count + 1);
  endfunction

  task automatic build_stimulus();
    int r;
    int mode;
    // directed part
    add_cmd(OP_POP, '0, 0);
    add_cmd(OP_NOP, '0, 0);
    add_cmd(OP_APPEND, 64'sh7FFF_FFFF_FFFF_FFFF, 0);
    add_cmd(OP_APPEND, 64'sh8000_0000_0000_0000, 0);
    add_cmd(OP_INSERT, -64'sd1, 1);
    add_cmd(OP_INSERT, '0, gen_count + 1);
    add_cmd(OP_INSERT, 64'sd5, 0);
    add_cmd(OP_INSERT, 64'sd6, gen_count + 2);
    add_cmd(OP_INSERT, 64'sd7, MAX_POSITION);
    add_cmd(OP_INSERT, {$urandom, $urandom}, 2);
    add_cmd(OP_APPEND, -64'sd2, MAX_POSITION);
    add_cmd(OP_POP, -64'sd1, MAX_POSITION);
    add_cmd(OP_NOP, -64'sd1, MAX_POSITION);
    while (gen_count > 0) add_cmd(OP_POP, '0, 0);
    add_cmd(OP_POP, '0, 0);
    add_cmd(OP_INSERT, 64'sh0123_4567_89AB_CDEF, 1);
    add_cmd(OP_POP, '0, 0);
    // random part: fill to full, drain, refill, then a mix
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      mode = (i < 350) ? 0 : (i < 600) ? 1 : (i < 800) ? 0 : 2;
      r = $urandom_range(0, 99);
      if (mode == 1) r = (r < 15) ? r * 3 : (r < 30) ? 45 + (r - 15) * 3 : (r < 95) ? 90 : 99;
      else if (mode == 2) r = (r < 30) ? r : (r < 60) ? r + 15 : (r < 95) ? 90 : 99;
      if (r < 45) add_cmd(OP_APPEND, rand_value(), $urandom_range(0, MAX_POSITION));
      else if (r < 88) add_cmd(OP_INSERT, rand_value(), rand_position());
      else if (r < 96) add_cmd(OP_POP, rand_value(), $urandom_range(0, MAX_POSITION));
      else add_cmd(OP_NOP, rand_value(), $urandom_range(0, MAX_POSITION));
    end
  endtask

  // Sender: hold while stalled, otherwise advance and maybe idle for a burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      calm     <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_queue_result(cmd_backlog[0]);
        cmd_backlog.delete(0);
        items_sent++;
      end
      calm <= (cmd_backlog.size() <= CALM_ITEMS);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid    <= 1'b1;
        in_opcode   <= cmd_backlog[0].op;
        in_value_in <= cmd_backlog[0].value;
        in_position <= cmd_backlog[0].position;
      end
    end
  end

  // Receiver stall: random bursts, plus the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %0d status %0d fill %0d",
                   out_value_out, out_status, out_fill_count);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_value_out !== want.value || out_status !== want.status ||
            out_fill_count !== want.fill) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected value %0d status %0d fill %0d, got value %0d status %0d fill %0d",
                     want.value, want.status, want.fill,
                     out_value_out, out_status, out_fill_count);
        end
      end
    end
  end

  // Let the queue back up behind a long receiver hold-off.
  initial begin
    while (items_sent < LONG_HOLD_START) @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    build_stimulus();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("tb_positional_insert_queue passed");
    else
      $display("tb_positional_insert_queue failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_positional_insert_queue failed");
    $finish;
  end

endmodule

// ===== positional_insert_queue.f =====
hw/rtl/piq_pkg.sv
hw/rtl/piq_cell.sv
hw/rtl/piq_ctrl.sv
hw/rtl/positional_insert_queue.sv
hw/rtl/piq_chk.sv
tb/sv/tb_positional_insert_queue.sv
